>>> rtl/grouped_intervention_accumulator_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grouped intervention accumulator
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GROUPED_INTERVENTION_ACCUMULATOR_TOP_MACROS_SVH
`define GROUPED_INTERVENTION_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and off while reset is held.
`define GIA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and off while reset is held.
`define GIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/gia_pkg.sv
// ----------------------------------------------------------------------------
// Grouped intervention accumulator package
// Item types, mode codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package gia_pkg;

  // Field widths fixed by the item format.
  localparam int GROUP_W  = 12;
  localparam int IDX_W    = 8;
  localparam int VALUE_W  = 32;
  localparam int ENTRY_W  = 64;
  localparam int IPG_W    = 9;
  localparam int MODE_W   = 2;
  // Full address before the range check: group times row length plus index.
  localparam int ADDR_FULL_W = GROUP_W + IPG_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = IPG_W;
  localparam logic [CFG_IDX_W-1:0] CFG_AGG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IPG      = 1'b1;

  // Item kinds.
  localparam logic KIND_ACC  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Aggregation modes: count, sum, sum of squares.
  typedef enum logic [MODE_W-1:0] {
    MODE_COUNT = 2'd0,
    MODE_SUM   = 2'd1,
    MODE_SUM_2 = 2'd2
  } mode_t;

  typedef struct packed {
    logic                      kind;
    logic [GROUP_W-1:0]        group_slot;
    logic [IDX_W-1:0]          annotation;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] entry_value;
    logic                      error;
  } out_item_t;

endpackage

>>> rtl/grouped_intervention_accumulator_top.sv
// ----------------------------------------------------------------------------
// Grouped intervention accumulator: scatter-add table in one synchronous RAM.
// Each item moves through the multiply, address and read states; the write-back
// and the result register are done on leaving the read state, where a stalled
// output holds the item. No new item is taken until the sequencer is back in idle.
// After reset a clearing pass zeroes every RAM entry; no item
// is taken until it ends. Configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module grouped_intervention_accumulator_top
  import gia_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic [ADDR_FULL_W-1:0] DEPTH_LIMIT = ADDR_FULL_W'(TABLE_DEPTH);
  localparam logic [AW-1:0]          LAST_ADDR   = AW'(TABLE_DEPTH - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_ADDR  = 5'b01000,
    ST_RD    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  mode_t            agg_mode_r;
  logic [IPG_W-1:0] ipg_r;

  // Item held while it is worked on.
  logic                      kind_r;
  logic [GROUP_W-1:0]        group_r;
  logic [IDX_W-1:0]          idx_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [ADDR_FULL_W-1:0]    prod_r;
  logic signed [ENTRY_W-1:0] sq_r;
  logic [AW-1:0]             addr_r;
  logic                      err_r;

  // Clearing pass.
  logic [AW-1:0] clr_addr_r;

  // Table memory and its ports.
  logic [ENTRY_W-1:0] acc_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               mem_re;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;

  // Output register.
  logic      out_valid_r;
  out_item_t out_data_r;

  logic                   in_take;
  logic [ADDR_FULL_W-1:0] addr_full;
  logic                   addr_err;
  logic                   need_out;
  logic                   out_busy;
  logic                   acc_en;
  logic [ENTRY_W-1:0]     incr;

  assign in_take  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // Row address and range check on the registered product.
  assign addr_full = prod_r + {{(ADDR_FULL_W - IDX_W){1'b0}}, idx_r};
  assign addr_err  = ({1'b0, idx_r} >= ipg_r) || (addr_full >= DEPTH_LIMIT);

  assign need_out = err_r || (kind_r == KIND_READ);
  assign out_busy = out_valid_r && out_stall;

  // Increment chosen by the mode; an unused mode leaves the entry alone.
  always_comb begin
    incr   = '0;
    acc_en = 1'b0;
    case (agg_mode_r)
      MODE_COUNT: begin
        incr   = ENTRY_W'(1);
        acc_en = 1'b1;
      end
      MODE_SUM: begin
        incr   = {{(ENTRY_W - VALUE_W){value_r[VALUE_W-1]}}, value_r};
        acc_en = 1'b1;
      end
      MODE_SUM_2: begin
        incr   = sq_r;
        acc_en = 1'b1;
      end
      default: begin
        incr   = '0;
        acc_en = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_take) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        state_nxt = ST_RD;
      end
      ST_RD: begin
        if (!(need_out && out_busy)) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // RAM port control: clearing writes, then at most a read and a write per item.
  assign mem_re = (state_r == ST_ADDR) && !addr_err;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = rd_data_r + incr;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (state_r == ST_RD && !err_r && kind_r == KIND_ACC && acc_en) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      acc_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= acc_mem[addr_full[AW-1:0]];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      agg_mode_r <= MODE_COUNT;
      ipg_r      <= IPG_W'(1);
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_AGG_MODE: agg_mode_r <= mode_t'(cfg_wdata[MODE_W-1:0]);
          CFG_IPG:      ipg_r      <= cfg_wdata;
          default:      ;
        endcase
      end
    end
  end

  // Item datapath: capture, multiply, then address and check.
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r  <= in_data.kind;
      group_r <= in_data.group_slot;
      idx_r   <= in_data.annotation;
      value_r <= in_data.value;
    end
    if (state_r == ST_MUL) begin
      prod_r <= {{IPG_W{1'b0}}, group_r} * {{GROUP_W{1'b0}}, ipg_r};
      sq_r   <= value_r * value_r;
    end
    if (state_r == ST_ADDR) begin
      addr_r <= addr_full[AW-1:0];
      err_r  <= addr_err;
    end
  end

  // Output register: loaded when an item ends with a result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RD && need_out && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RD && need_out && !out_busy) begin
      out_data_r.error       <= err_r;
      out_data_r.entry_value <= err_r ? '0 : rd_data_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks on the sequencer and the RAM traffic.
`include "grouped_intervention_accumulator_top_macros.svh"

  `GIA_ASSERT_NOW(a_no_take_in_clear, state_r == ST_CLEAR, in_stall, "item taken during clear")
  `GIA_ASSERT_NOW(a_rd_wr_apart, mem_re, !mem_we, "RAM read and write in one cycle")
  `GIA_ASSERT_NOW(a_wr_only_acc, mem_we && state_r == ST_RD, !err_r && kind_r == KIND_ACC, "bad write-back")
  `GIA_ASSERT_NEXT(a_take_to_mul, in_take, state_r == ST_MUL && !out_valid_r || state_r == ST_MUL, "sequencer skipped multiply")

endmodule
